// ===== rtl/assert_macros.svh =====
// assertion helpers used by rcsr_datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RCSR_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcsr assertion failed");

// next-cycle implication
`define RCSR_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcsr assertion failed");

`endif

// ===== rtl/rcsr_pkg.sv =====
package rcsr_pkg;

  typedef logic [3:0]  cmd_type_t;
  typedef logic [2:0]  slot_t;
  typedef logic [31:0] handle_t;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int RUN_DEPTH_DEF  = 16;
  localparam int FIXED_CNT      = 5;

  localparam cmd_type_t TYPE_DRAW_LAST = 4'd3;
  localparam cmd_type_t TYPE_TOPOLOGY  = 4'd4;
  localparam cmd_type_t TYPE_BLEND     = 4'd5;
  localparam cmd_type_t TYPE_VBUF      = 4'd6;
  localparam cmd_type_t TYPE_IBUF      = 4'd7;
  localparam cmd_type_t TYPE_PIPELINE  = 4'd8;
  localparam cmd_type_t TYPE_CBUF      = 4'd9;
  localparam cmd_type_t TYPE_SAMPLER   = 4'd10;
  localparam cmd_type_t TYPE_TEX       = 4'd11;
  localparam cmd_type_t TYPE_RT_TEX    = 4'd12;
  localparam cmd_type_t TYPE_PASS      = 4'd13;

  typedef enum logic [2:0] {
    EM_PASS,
    EM_STATE,
    EM_REPLAY,
    EM_CMD,
    EM_OVF
  } emit_sel_t;

  typedef struct packed {
    logic      in_ready;
    logic      mem_rd;
    logic      fl_start;
    logic      fl_step;
    logic      ins;
    logic      clr_held;
    logic      clr_list;
    logic      rp_start;
    logic      rp_step;
    logic      rp_clr_pend;
    logic      emit;
    emit_sel_t emit_sel;
    logic      emit_last;
  } ctl_t;

  typedef struct packed {
    logic en;
    logic is_draw;
    logic is_known;
    logic eol;
    logic full;
    logic held_empty;
    logic pend;
    logic k_at_np;
    logic k_at_ns;
    logic ns_zero;
    logic k_last_p;
    logic k_last_s;
    logic rp_done;
    logic rp_hit;
    logic out_free;
  } sts_t;

  function automatic slot_t slot_of(cmd_type_t t, slot_t s);
    return (t >= TYPE_CBUF && t <= TYPE_RT_TEX) ? s : 3'd0;
  endfunction

  // -1 when the command is not remembered
  function automatic int shadow_index(cmd_type_t t, slot_t s, int slot_count);
    unique case (t)
      TYPE_PIPELINE: return 0;
      TYPE_TOPOLOGY: return 1;
      TYPE_BLEND:    return 2;
      TYPE_VBUF:     return 3;
      TYPE_IBUF:     return 4;
      default:       ;
    endcase
    if (int'(s) >= slot_count) return -1;
    if (t == TYPE_CBUF) return FIXED_CNT + int'(s);
    if (t == TYPE_SAMPLER) return FIXED_CNT + slot_count + int'(s);
    if (t == TYPE_TEX || t == TYPE_RT_TEX) return FIXED_CNT + 2 * slot_count + int'(s);
    return -1;
  endfunction

  function automatic cmd_type_t fixed_kind(logic [2:0] i);
    unique case (i)
      3'd0:    return TYPE_PIPELINE;
      3'd1:    return TYPE_TOPOLOGY;
      3'd2:    return TYPE_BLEND;
      3'd3:    return TYPE_VBUF;
      default: return TYPE_IBUF;
    endcase
  endfunction

endpackage

// ===== rtl/rcsr_cmd_if.sv =====
interface rcsr_cmd_if import rcsr_pkg::*; ;
  logic      valid;
  logic      ready;
  cmd_type_t cmd_type;
  slot_t     slot;
  handle_t   payload_handle;
  logic      end_of_list;

  modport source (output valid, cmd_type, slot, payload_handle, end_of_list, input ready);
  modport sink (input valid, cmd_type, slot, payload_handle, end_of_list, output ready);
endinterface

// ===== rtl/rcsr_res_if.sv =====
interface rcsr_res_if import rcsr_pkg::*; ;
  logic      valid;
  logic      ready;
  cmd_type_t out_type;
  slot_t     out_slot;
  handle_t   out_handle;
  logic      is_replay;
  logic      run_overflow;
  logic      last_of_burst;

  modport source (output valid, out_type, out_slot, out_handle, is_replay, run_overflow,
                  last_of_burst, input ready);
  modport sink (input valid, out_type, out_slot, out_handle, is_replay, run_overflow,
                last_of_burst, output ready);
endinterface

// ===== rtl/rcsr_datapath.sv =====
`include "assert_macros.svh"

module rcsr_datapath import rcsr_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int RUN_DEPTH  = RUN_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  rcsr_cmd_if.sink     in_ch,
  rcsr_res_if.source   out_ch,
  input  ctl_t         ctl,
  output sts_t         sts
);

  localparam int SH_DEPTH = FIXED_CNT + 3 * SLOT_COUNT;
  localparam int SHW      = $clog2(SH_DEPTH);
  localparam int SIW      = $clog2(SH_DEPTH + 1);
  localparam int CW       = $clog2(RUN_DEPTH + 1);
  localparam int IW       = $clog2(RUN_DEPTH);
  localparam int SCW      = $clog2(SLOT_COUNT + 1);

  logic              en_r;
  cmd_type_t         t_r;
  slot_t             s_r;
  handle_t           h_r;
  logic              eol_r;
  logic [CW-1:0]     np_r, ns_r, k_r;
  logic [CW:0]       held_sum;
  handle_t           pass_mem [RUN_DEPTH];
  logic [38:0]       state_mem [RUN_DEPTH];
  handle_t           rd_pass_r;
  logic [38:0]       rd_state_r;
  logic [SH_DEPTH-1:0] sh_valid_r, sh_before_r, sh_alt_r;
  handle_t           sh_handle_r [SH_DEPTH];
  logic              pend_r;
  logic [SIW-1:0]    sw_idx_r;
  logic [1:0]        sw_grp_r;
  logic [SCW-1:0]    sw_slot_r;
  logic [SHW-1:0]    sw_pos;
  logic              sw_fixed;
  cmd_type_t         rp_type;
  int                st_idx;
  logic              out_free;
  logic              in_acc;

  logic              ov_r, rep_r, ovf_r, last_r;
  cmd_type_t         ot_r;
  slot_t             os_r;
  handle_t           oh_r;

  assign held_sum = {1'b0, np_r} + {1'b0, ns_r};
  assign out_free = !ov_r || out_ch.ready;
  assign in_acc   = ctl.in_ready && in_ch.valid;
  assign in_ch.ready = ctl.in_ready;
  assign sw_pos   = sw_idx_r[SHW-1:0];
  assign sw_fixed = sw_idx_r < SIW'(FIXED_CNT);
  assign st_idx   = shadow_index(rd_state_r[38:35], rd_state_r[34:32], SLOT_COUNT);

  always_comb begin
    priority if (sw_fixed) begin
      rp_type = fixed_kind(sw_idx_r[2:0]);
    end else if (sw_grp_r == 2'd0) begin
      rp_type = TYPE_CBUF;
    end else if (sw_grp_r == 2'd1) begin
      rp_type = TYPE_SAMPLER;
    end else begin
      rp_type = sh_alt_r[sw_pos] ? TYPE_RT_TEX : TYPE_TEX;
    end
  end

  always_comb begin
    sts.en         = en_r;
    sts.is_draw    = t_r <= TYPE_DRAW_LAST;
    sts.is_known   = t_r <= TYPE_PASS;
    sts.eol        = eol_r;
    sts.full       = held_sum >= (CW+1)'(RUN_DEPTH);
    sts.held_empty = held_sum == '0;
    sts.pend       = pend_r;
    sts.k_at_np    = k_r == np_r;
    sts.k_at_ns    = k_r == ns_r;
    sts.ns_zero    = ns_r == '0;
    sts.k_last_p   = k_r + CW'(1) == np_r;
    sts.k_last_s   = k_r + CW'(1) == ns_r;
    sts.rp_done    = sw_idx_r == SIW'(SH_DEPTH);
    sts.rp_hit     = sh_valid_r[sw_pos] && sh_before_r[sw_pos];
    sts.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      en_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      t_r   <= in_ch.cmd_type;
      s_r   <= in_ch.slot;
      h_r   <= in_ch.payload_handle;
      eol_r <= in_ch.end_of_list;
    end
  end

  // held run buffers
  always_ff @(posedge clk) begin
    if (ctl.ins && t_r == TYPE_PASS) begin
      pass_mem[np_r[IW-1:0]] <= h_r;
    end
    if (ctl.ins && t_r != TYPE_PASS) begin
      state_mem[ns_r[IW-1:0]] <= {t_r, slot_of(t_r, s_r), h_r};
    end
    if (ctl.mem_rd) begin
      rd_pass_r  <= pass_mem[k_r[IW-1:0]];
      rd_state_r <= state_mem[k_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      np_r <= '0;
      ns_r <= '0;
      k_r  <= '0;
    end else begin
      if (ctl.clr_held) begin
        np_r <= '0;
        ns_r <= '0;
      end else if (ctl.ins && t_r == TYPE_PASS) begin
        np_r <= np_r + CW'(1);
      end else if (ctl.ins) begin
        ns_r <= ns_r + CW'(1);
      end
      if (ctl.fl_start) begin
        k_r <= '0;
      end else if (ctl.fl_step) begin
        k_r <= k_r + CW'(1);
      end
    end
  end

  // shadow table control bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_valid_r  <= '0;
      sh_before_r <= '0;
      sh_alt_r    <= '0;
      pend_r      <= 1'b1;
    end else if (ctl.clr_list) begin
      sh_valid_r <= '0;
      pend_r     <= 1'b1;
    end else if (ctl.emit && ctl.emit_sel == EM_PASS) begin
      sh_before_r <= sh_before_r | sh_valid_r;
      pend_r      <= 1'b1;
    end else if (ctl.emit && ctl.emit_sel == EM_STATE && st_idx >= 0) begin
      sh_valid_r[SHW'(st_idx)]  <= 1'b1;
      sh_before_r[SHW'(st_idx)] <= 1'b0;
      sh_alt_r[SHW'(st_idx)]    <= rd_state_r[38:35] == TYPE_RT_TEX;
    end else if (ctl.rp_clr_pend) begin
      pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit && ctl.emit_sel == EM_STATE && st_idx >= 0) begin
      sh_handle_r[SHW'(st_idx)] <= rd_state_r[31:0];
    end
  end

  // replay sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_idx_r  <= '0;
      sw_grp_r  <= '0;
      sw_slot_r <= '0;
    end else if (ctl.rp_start) begin
      sw_idx_r  <= '0;
      sw_grp_r  <= '0;
      sw_slot_r <= '0;
    end else if (ctl.rp_step) begin
      sw_idx_r <= sw_idx_r + SIW'(1);
      if (!sw_fixed) begin
        if (sw_slot_r == SCW'(SLOT_COUNT - 1)) begin
          sw_slot_r <= '0;
          sw_grp_r  <= sw_grp_r + 2'd1;
        end else begin
          sw_slot_r <= sw_slot_r + SCW'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (ctl.emit) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      last_r <= ctl.emit_last;
      rep_r  <= 1'b0;
      ovf_r  <= 1'b0;
      unique case (ctl.emit_sel)
        EM_PASS: begin
          ot_r <= TYPE_PASS;
          os_r <= '0;
          oh_r <= rd_pass_r;
        end
        EM_STATE: begin
          ot_r <= rd_state_r[38:35];
          os_r <= rd_state_r[34:32];
          oh_r <= rd_state_r[31:0];
        end
        EM_REPLAY: begin
          ot_r  <= rp_type;
          os_r  <= sw_fixed ? 3'd0 : 3'(sw_slot_r);
          oh_r  <= sh_handle_r[sw_pos];
          rep_r <= 1'b1;
        end
        EM_CMD: begin
          ot_r <= t_r;
          os_r <= slot_of(t_r, s_r);
          oh_r <= h_r;
        end
        default: begin
          ot_r  <= '0;
          os_r  <= '0;
          oh_r  <= '0;
          ovf_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.out_type      = ot_r;
  assign out_ch.out_slot      = os_r;
  assign out_ch.out_handle    = oh_r;
  assign out_ch.is_replay     = rep_r;
  assign out_ch.run_overflow  = ovf_r;
  assign out_ch.last_of_burst = last_r;

  `RCSR_AST_IMP(a_emit_free, ctl.emit, out_free)
  `RCSR_AST_IMP(a_ins_room, ctl.ins, held_sum < (CW+1)'(RUN_DEPTH))
  `RCSR_AST_IMP(a_held_bound, 1'b1, held_sum <= (CW+1)'(RUN_DEPTH))
  `RCSR_AST_NXT(a_clear_list, ctl.clr_list, sh_valid_r == '0 && pend_r)

endmodule

// ===== rtl/rcsr_ctrl.sv =====
module rcsr_ctrl import rcsr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  sts_t sts,
  output ctl_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_FLP_RD,
    S_FLP_EM,
    S_FLS_RD,
    S_FLS_EM,
    S_RP_START,
    S_RP,
    S_CMD,
    S_INS,
    S_CLEAR
  } state_t;

  state_t state_r, state_nxt;
  logic   pre_r, rp_r, cmd_r, ins_r, post_r, clr_r, pre_fin_r, in_post_r;
  logic   pre_nxt, rp_nxt, cmd_nxt, ins_nxt, post_nxt, clr_nxt, pre_fin_nxt, in_post_nxt;
  logic   fin;

  assign fin = in_post_r || pre_fin_r;

  always_comb begin
    ctl          = '0;
    ctl.emit_sel = EM_CMD;
    state_nxt    = state_r;
    pre_nxt      = pre_r;
    rp_nxt       = rp_r;
    cmd_nxt      = cmd_r;
    ins_nxt      = ins_r;
    post_nxt     = post_r;
    clr_nxt      = clr_r;
    pre_fin_nxt  = pre_fin_r;
    in_post_nxt  = in_post_r;
    unique case (state_r)
      S_IDLE: begin
        ctl.in_ready = 1'b1;
        if (in_valid) state_nxt = S_DEC;
      end
      S_DEC: begin
        pre_nxt     = !sts.en || sts.is_draw;
        rp_nxt      = sts.en && sts.is_draw;
        cmd_nxt     = (!sts.en && sts.is_known) || (sts.en && sts.is_draw) ||
                      (sts.en && sts.is_known && sts.full);
        ins_nxt     = sts.en && sts.is_known && !sts.is_draw && !sts.full;
        post_nxt    = sts.en && sts.eol;
        clr_nxt     = !sts.en || sts.eol;
        pre_fin_nxt = !cmd_nxt;
        in_post_nxt = 1'b0;
        ctl.fl_start = 1'b1;
        priority if (pre_nxt) state_nxt = S_FLP_RD;
        else if (cmd_nxt) state_nxt = S_CMD;
        else if (ins_nxt) state_nxt = S_INS;
        else if (post_nxt) begin
          in_post_nxt = 1'b1;
          state_nxt   = S_FLP_RD;
        end else state_nxt = S_IDLE;
      end
      S_FLP_RD: begin
        if (sts.k_at_np) begin
          ctl.fl_start = 1'b1;
          state_nxt    = S_FLS_RD;
        end else begin
          ctl.mem_rd = 1'b1;
          state_nxt  = S_FLP_EM;
        end
      end
      S_FLP_EM: begin
        if (sts.out_free) begin
          ctl.emit      = 1'b1;
          ctl.emit_sel  = EM_PASS;
          ctl.emit_last = fin && sts.k_last_p && sts.ns_zero;
          ctl.fl_step   = 1'b1;
          state_nxt     = S_FLP_RD;
        end
      end
      S_FLS_RD: begin
        if (sts.k_at_ns) begin
          ctl.clr_held = 1'b1;
          priority if (in_post_r) state_nxt = S_CLEAR;
          else if (rp_r) state_nxt = S_RP_START;
          else if (cmd_r) state_nxt = S_CMD;
          else state_nxt = S_CLEAR;
        end else begin
          ctl.mem_rd = 1'b1;
          state_nxt  = S_FLS_EM;
        end
      end
      S_FLS_EM: begin
        if (sts.out_free) begin
          ctl.emit      = 1'b1;
          ctl.emit_sel  = EM_STATE;
          ctl.emit_last = fin && sts.k_last_s;
          ctl.fl_step   = 1'b1;
          state_nxt     = S_FLS_RD;
        end
      end
      S_RP_START: begin
        if (sts.pend) begin
          ctl.rp_start = 1'b1;
          state_nxt    = S_RP;
        end else begin
          state_nxt = S_CMD;
        end
      end
      S_RP: begin
        priority if (sts.rp_done) begin
          ctl.rp_clr_pend = 1'b1;
          state_nxt       = S_CMD;
        end else if (sts.rp_hit) begin
          if (sts.out_free) begin
            ctl.emit     = 1'b1;
            ctl.emit_sel = EM_REPLAY;
            ctl.rp_step  = 1'b1;
          end
        end else begin
          ctl.rp_step = 1'b1;
        end
      end
      S_CMD: begin
        if (sts.out_free) begin
          ctl.emit      = 1'b1;
          ctl.emit_sel  = (sts.en && !sts.is_draw) ? EM_OVF : EM_CMD;
          ctl.emit_last = !(post_r && !sts.held_empty);
          priority if (post_r) begin
            ctl.fl_start = 1'b1;
            in_post_nxt  = 1'b1;
            state_nxt    = S_FLP_RD;
          end else if (clr_r) state_nxt = S_CLEAR;
          else state_nxt = S_IDLE;
        end
      end
      S_INS: begin
        ctl.ins = 1'b1;
        if (post_r) begin
          ctl.fl_start = 1'b1;
          in_post_nxt  = 1'b1;
          state_nxt    = S_FLP_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        ctl.clr_list = 1'b1;
        state_nxt    = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pre_r     <= 1'b0;
      rp_r      <= 1'b0;
      cmd_r     <= 1'b0;
      ins_r     <= 1'b0;
      post_r    <= 1'b0;
      clr_r     <= 1'b0;
      pre_fin_r <= 1'b0;
      in_post_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pre_r     <= pre_nxt;
      rp_r      <= rp_nxt;
      cmd_r     <= cmd_nxt;
      ins_r     <= ins_nxt;
      post_r    <= post_nxt;
      clr_r     <= clr_nxt;
      pre_fin_r <= pre_fin_nxt;
      in_post_r <= in_post_nxt;
    end
  end

endmodule

// ===== rtl/render_command_stream_rewriter_unit.sv =====
// render command stream rewriter
// in_ch carries one command per transaction (type, slot, payload handle,
// end of list); out_ch carries the rewritten commands, each with replay,
// overflow and last-of-burst flags. cfg_wr_en/cfg_wr_data write the
// reorder enable; the user must do so only while the block is idle, which
// the block itself does not enforce. one command is handled at a time:
// in_ch.ready is high only between commands. a command may be only held,
// emitted as an overflow or dropped as an unknown type; a draw or a
// pass-through command first flushes the held run, and a replay then sweeps
// every shadow table entry (5 + 3 * SLOT_COUNT); end of list adds a final
// flush and table clear. the held run sits in two buffer memories with a
// registered read port, so each flushed command is read, then emitted.
// results leave through an output register, so the next result is prepared
// while one waits; a stalled out_ch simply holds the sequencer in place and
// no result is lost. reset empties the held run, invalidates the shadow
// table, arms the replay and turns reordering off; no clearing pass is needed.
module render_command_stream_rewriter_unit import rcsr_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int RUN_DEPTH  = RUN_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  rcsr_cmd_if.sink   in_ch,
  rcsr_res_if.source out_ch
);

  ctl_t ctl;
  sts_t sts;

  rcsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .ctl      (ctl)
  );

  rcsr_datapath #(
    .SLOT_COUNT (SLOT_COUNT),
    .RUN_DEPTH  (RUN_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .ctl         (ctl),
    .sts         (sts)
  );

endmodule
